// ----- hdl/glw_pkg.sv -----
// Package: shared widths, word types and controller/datapath interface for the grid line walk.
`default_nettype none

package glw_pkg;

  // Coordinate format and slope precision
  localparam int unsigned COORD_INT_BITS  = 5;
  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned SLOPE_FRAC_BITS = 16;
  localparam int unsigned COORD_BITS      = COORD_INT_BITS + COORD_FRAC_BITS;

  // Tile index width of the result word
  localparam int unsigned TILE_BITS = 5;

  // Derived datapath widths
  localparam int unsigned DIV_BITS     = COORD_BITS + SLOPE_FRAC_BITS;
  localparam int unsigned SLOPE_BITS   = DIV_BITS + 1;
  localparam int unsigned DIFF_BITS    = COORD_BITS + 2;
  localparam int unsigned PROD_BITS    = SLOPE_BITS + DIFF_BITS;
  localparam int unsigned SUM_BITS     = PROD_BITS + 1;
  localparam int unsigned ROW_SHIFT    = COORD_FRAC_BITS + SLOPE_FRAC_BITS;
  localparam int unsigned ROW_Y_BITS   = SUM_BITS - ROW_SHIFT;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_BITS);

  // Input word: one line request
  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } line_req_t;

  // Output word: one crossed tile
  typedef struct packed {
    logic [TILE_BITS-1:0] tile_col;
    logic [TILE_BITS-1:0] tile_row;
    logic                 last_tile;
  } tile_word_t;

  // Which tile the datapath emits
  typedef enum logic [1:0] {
    TILE_START,
    TILE_ROW,
    TILE_COL
  } tile_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       mul;
    logic       row;
    logic       emit;
    tile_kind_e kind;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic cols_zero;
    logic cols_one;
    logic at_target;
    logic start_last;
    logic row_last;
    logic col_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/glw_ctrl.sv -----
// Controller: sequences load, slope division, border row evaluation and tile emission.
`default_nettype none

module glw_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire glw_pkg::dp_sts_t sts_i,
  output glw_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ROW,
    ST_WALK
  } state_e;

  state_e                              state_q;
  logic [glw_pkg::DIV_CNT_BITS-1:0]    cnt_q;

  assign in_stall_o = (state_q != ST_IDLE);

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = glw_pkg::TILE_START;
    case (state_q)
      ST_IDLE:  cmd_o.load     = in_valid_i;
      ST_START: cmd_o.emit     = sts_i.out_free;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_ROW:   cmd_o.row      = 1'b1;
      ST_WALK: begin
        cmd_o.kind = sts_i.at_target ? glw_pkg::TILE_COL : glw_pkg::TILE_ROW;
        cmd_o.emit = sts_i.out_free;
      end
      default:  cmd_o.load     = 1'b0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_START;
          end
        end
        ST_START: begin
          cnt_q <= '0;
          if (sts_i.out_free) begin
            if (sts_i.start_last) begin
              state_q <= ST_IDLE;
            end else if (sts_i.cols_zero) begin
              state_q <= ST_WALK;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == glw_pkg::DIV_CNT_BITS'(glw_pkg::DIV_BITS - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_ROW;
        ST_ROW: state_q <= ST_WALK;
        ST_WALK: begin
          if (sts_i.out_free) begin
            if (sts_i.at_target) begin
              // column step
              if (sts_i.col_last) begin
                state_q <= ST_IDLE;
              end else if (!sts_i.cols_one) begin
                state_q <= ST_MUL;
              end
            end else if (sts_i.row_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/glw_datapath.sv -----
// Datapath: request registers, restoring slope divider, border row unit and output register.
`default_nettype none

module glw_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire glw_pkg::line_req_t in_word_i,
  input  wire glw_pkg::dp_cmd_t  cmd_i,
  output glw_pkg::dp_sts_t       sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output glw_pkg::tile_word_t    out_word_o
);

  localparam int unsigned CB = glw_pkg::COORD_BITS;
  localparam int unsigned TB = glw_pkg::TILE_BITS;
  localparam int unsigned FB = glw_pkg::COORD_FRAC_BITS;

  // Request and walk registers
  logic [CB-1:0]                       tx_q, ty_q;
  logic [TB-1:0]                       y2_q, lo_q, hi_q;
  logic [TB-1:0]                       col_q, last_q, target_q, cols_q;
  logic                                right_q, neg_q;
  logic [CB-1:0]                       den_q, rem_q;
  logic [glw_pkg::DIV_BITS-1:0]        num_q;
  logic signed [glw_pkg::PROD_BITS-1:0] prod_q;
  glw_pkg::tile_word_t                 out_q;
  logic                                out_valid_q;

  // Load decode
  logic [TB-1:0] x1, y1, x2, y2;
  logic          dy_neg, dx_neg;
  logic [CB-1:0] dy_mag, dx_mag;

  assign x1     = in_word_i.start_x[CB-1:FB];
  assign y1     = in_word_i.start_y[CB-1:FB];
  assign x2     = in_word_i.end_x[CB-1:FB];
  assign y2     = in_word_i.end_y[CB-1:FB];
  assign dy_neg = in_word_i.end_y < in_word_i.start_y;
  assign dx_neg = in_word_i.end_x < in_word_i.start_x;
  assign dy_mag = dy_neg ? (in_word_i.start_y - in_word_i.end_y)
                         : (in_word_i.end_y - in_word_i.start_y);
  assign dx_mag = dx_neg ? (in_word_i.start_x - in_word_i.end_x)
                         : (in_word_i.end_x - in_word_i.start_x);

  // Divider step: one quotient bit a cycle
  logic [CB:0]   div_t;
  logic          div_ge;
  assign div_t  = {rem_q, num_q[glw_pkg::DIV_BITS-1]};
  assign div_ge = div_t >= {1'b0, den_q};

  // Signed slope from quotient
  logic signed [glw_pkg::SLOPE_BITS-1:0] k_s;
  assign k_s = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

  // Border column offset from end point
  logic [TB:0]                          bx;
  logic signed [glw_pkg::DIFF_BITS-1:0] diff_s;
  assign bx     = right_q ? ({1'b0, col_q} + (TB+1)'(1)) : {1'b0, col_q};
  assign diff_s = $signed(glw_pkg::DIFF_BITS'(bx) << FB)
                - $signed(glw_pkg::DIFF_BITS'(tx_q));

  // Border row: floor and clamp
  logic signed [glw_pkg::SUM_BITS-1:0]   ny_s;
  logic signed [glw_pkg::ROW_Y_BITS-1:0] yf_s, lo_s, hi_s;
  logic [TB-1:0]                         row_clamp;
  assign ny_s = $signed(glw_pkg::SUM_BITS'(ty_q) << glw_pkg::SLOPE_FRAC_BITS)
              + glw_pkg::SUM_BITS'(prod_q);
  assign yf_s = $signed(ny_s[glw_pkg::SUM_BITS-1:glw_pkg::ROW_SHIFT]);
  assign lo_s = $signed(glw_pkg::ROW_Y_BITS'(lo_q));
  assign hi_s = $signed(glw_pkg::ROW_Y_BITS'(hi_q));
  always_comb begin
    if (yf_s < lo_s) begin
      row_clamp = lo_q;
    end else if (yf_s > hi_s) begin
      row_clamp = hi_q;
    end else begin
      row_clamp = yf_s[TB-1:0];
    end
  end

  // Next tile candidates
  logic [TB-1:0] next_row, next_col;
  assign next_row = (target_q > last_q) ? (last_q + 1'b1) : (last_q - 1'b1);
  assign next_col = right_q ? (col_q + 1'b1) : (col_q - 1'b1);

  // Status
  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
    sts_o.cols_zero  = (cols_q == '0);
    sts_o.cols_one   = (cols_q == TB'(1));
    sts_o.at_target  = (last_q == target_q);
    sts_o.start_last = sts_o.cols_zero && (last_q == y2_q);
    sts_o.row_last   = sts_o.cols_zero && (next_row == target_q);
    sts_o.col_last   = sts_o.cols_one && (target_q == y2_q);
  end

  // Tile word to emit
  glw_pkg::tile_word_t tile_d;
  always_comb begin
    case (cmd_i.kind)
      glw_pkg::TILE_START: tile_d = '{tile_col: col_q, tile_row: last_q,
                                      last_tile: sts_o.start_last};
      glw_pkg::TILE_ROW:   tile_d = '{tile_col: col_q, tile_row: next_row,
                                      last_tile: sts_o.row_last};
      glw_pkg::TILE_COL:   tile_d = '{tile_col: next_col, tile_row: target_q,
                                      last_tile: sts_o.col_last};
      default:             tile_d = '{tile_col: col_q, tile_row: last_q,
                                      last_tile: 1'b0};
    endcase
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q     <= in_word_i.end_x;
      ty_q     <= in_word_i.end_y;
      y2_q     <= y2;
      lo_q     <= (y1 < y2) ? y1 : y2;
      hi_q     <= (y1 < y2) ? y2 : y1;
      col_q    <= x1;
      last_q   <= y1;
      target_q <= y2;
      cols_q   <= (x2 >= x1) ? (x2 - x1) : (x1 - x2);
      right_q  <= in_word_i.end_x > in_word_i.start_x;
      neg_q    <= dy_neg ^ dx_neg;
      den_q    <= dx_mag;
      rem_q    <= '0;
      num_q    <= glw_pkg::DIV_BITS'(dy_mag) << glw_pkg::SLOPE_FRAC_BITS;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? CB'(div_t - {1'b0, den_q}) : div_t[CB-1:0];
      num_q <= {num_q[glw_pkg::DIV_BITS-2:0], div_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= k_s * diff_s;
    end
    if (cmd_i.row) begin
      target_q <= row_clamp;
    end
    if (cmd_i.emit) begin
      out_q <= tile_d;
      if (cmd_i.kind == glw_pkg::TILE_ROW) begin
        last_q <= next_row;
      end else if (cmd_i.kind == glw_pkg::TILE_COL) begin
        col_q  <= next_col;
        cols_q <= cols_q - 1'b1;
        // entering the end column: walk toward the end row
        if (sts_o.cols_one) begin
          target_q <= y2_q;
        end
      end
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/grid_line_tile_walk_unit.sv -----
// Top level: four-connected grid line tile walk, controller plus datapath.
//
//   channel | direction | word type   | handshake
//   in      | input     | line_req_t  | in_valid_i / in_stall_o
//   out     | output    | tile_word_t | out_valid_o / out_stall_i
//
// A request emits its start tile, runs the bit-serial slope divider (skipped when
// start and end share a column), then for each further column computes the border
// row (multiply, then row and clamp) and emits the tiles up to it; the next word is
// accepted only once the last tile of the request has been emitted.
// Reset is asynchronous and clears the controller and output valid; an output
// stall holds the word and pauses the walk, and the input stalls during a walk.
`default_nettype none

module grid_line_tile_walk_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire glw_pkg::line_req_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output glw_pkg::tile_word_t     out_word_o
);

  glw_pkg::dp_cmd_t cmd;
  glw_pkg::dp_sts_t sts;

  glw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- test/grid_line_tile_walk_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the grid line tile walk: line requests in, every crossed tile checked in order.
module grid_line_tile_walk_unit_tb;

  localparam int MAX_TILES    = 63;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_TIME  = 200;
  localparam int RANDOM_LINES = 144;
  localparam int COORD_MAX    = (1 << glw_pkg::COORD_BITS) - 1;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  glw_pkg::line_req_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  glw_pkg::tile_word_t out_word;

  // Expected tiles, oldest first, and the line being predicted
  glw_pkg::tile_word_t tile_queue[$];
  glw_pkg::tile_word_t pending_tile;
  int                  line_tile_count;

  int error_count   = 0;
  int lines_sent    = 0;
  int tiles_checked = 0;
  int burst_left    = 0;

  // Receiver stall pattern and long hold-off bookkeeping
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int run_left      = 0;
  int stall_mode    = 0;

  grid_line_tile_walk_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk_i = ~clk_i;

  // Queue one tile of the current line; the previous one is known not to be last
  function automatic void add_tile(input longint col, input longint row);
    if (line_tile_count < MAX_TILES) begin
      if (line_tile_count > 0) tile_queue.push_back(pending_tile);
      pending_tile.tile_col  = col[glw_pkg::TILE_BITS-1:0];
      pending_tile.tile_row  = row[glw_pkg::TILE_BITS-1:0];
      pending_tile.last_tile = 1'b0;
      line_tile_count++;
    end
  endfunction

  // Work out every tile a request crosses, column by column
  task automatic predict_tiles(input glw_pkg::line_req_t req);
    longint sx, sy, ex, ey, dx, dy, slope, col_dir;
    longint col, cur_row, r_end, c_end, row_lo, row_hi, cols, border, acc, row;
    sx = req.start_x;
    sy = req.start_y;
    ex = req.end_x;
    ey = req.end_y;
    slope = 0;
    if (ex != sx) begin
      dx = ex - sx;
      dy = ey - sy;
      slope = ((dy < 0 ? -dy : dy) <<< glw_pkg::SLOPE_FRAC_BITS) / (dx < 0 ? -dx : dx);
      if ((dy < 0) != (dx < 0)) slope = -slope;
    end
    col_dir = (ex > sx) ? 1 : -1;
    col     = sx >>> glw_pkg::COORD_FRAC_BITS;
    cur_row = sy >>> glw_pkg::COORD_FRAC_BITS;
    c_end   = ex >>> glw_pkg::COORD_FRAC_BITS;
    r_end   = ey >>> glw_pkg::COORD_FRAC_BITS;
    row_lo  = (cur_row < r_end) ? cur_row : r_end;
    row_hi  = (cur_row < r_end) ? r_end : cur_row;
    cols    = (c_end > col) ? c_end - col : col - c_end;
    line_tile_count = 0;
    add_tile(col, cur_row);
    repeat (cols) begin
      col += col_dir;
      // border is the left edge of the new column walking right, its right edge walking left
      border = (col_dir > 0) ? col : col + 1;
      acc = (ey <<< glw_pkg::SLOPE_FRAC_BITS)
          + slope * ((border <<< glw_pkg::COORD_FRAC_BITS) - ex);
      row = acc >>> glw_pkg::ROW_SHIFT;
      if (row < row_lo) row = row_lo;
      if (row > row_hi) row = row_hi;
      while (cur_row != row) begin
        cur_row += (row > cur_row) ? 1 : -1;
        add_tile(col - col_dir, cur_row);
      end
      add_tile(col, row);
    end
    // remaining rows in the end column
    while (cur_row != r_end) begin
      cur_row += (r_end > cur_row) ? 1 : -1;
      add_tile(col, cur_row);
    end
    pending_tile.last_tile = 1'b1;
    tile_queue.push_back(pending_tile);
  endtask

  task automatic note_error(input string msg);
    if (error_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Predict on each accepted request word, check each accepted tile word
  always @(posedge clk_i) begin
    glw_pkg::tile_word_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_tiles(in_word);
      if (out_valid && !out_stall) begin
        tiles_checked++;
        if (tile_queue.size() == 0) begin
          note_error($sformatf("unexpected tile col %0d row %0d last %0b",
                               out_word.tile_col, out_word.tile_row, out_word.last_tile));
        end else begin
          want = tile_queue.pop_front();
          if (out_word.tile_col !== want.tile_col || out_word.tile_row !== want.tile_row ||
              out_word.last_tile !== want.last_tile)
            note_error($sformatf({"tile expected col %0d row %0d last %0b, ",
                                  "got col %0d row %0d last %0b"},
                                 want.tile_col, want.tile_row, want.last_tile,
                                 out_word.tile_col, out_word.tile_row, out_word.last_tile));
        end
      end
    end
  end

  // Receiver: runs of no, light or heavy stalling, plus long hold-offs on request
  always @(posedge clk_i) begin
    logic stall_next;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left  = HOLD_CYCLES;
      stall_next = 1'b1;
    end else begin
      if (run_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        run_left   = $urandom_range(20, 120);
      end
      run_left--;
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 7) == 0);
        default: stall_next = $urandom_range(0, 1);
      endcase
    end
    out_stall <= stall_next;
  end

  // Offer one request word and hold it until accepted; bursts with random gaps
  task automatic send_line(input glw_pkg::line_req_t req);
    in_valid <= 1'b1;
    in_word  <= req;
    do @(posedge clk_i); while (in_stall);
    lines_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic send_points(input int sx, input int sy, input int ex, input int ey);
    glw_pkg::line_req_t req;
    req.start_x = sx[glw_pkg::COORD_BITS-1:0];
    req.start_y = sy[glw_pkg::COORD_BITS-1:0];
    req.end_x   = ex[glw_pkg::COORD_BITS-1:0];
    req.end_y   = ey[glw_pkg::COORD_BITS-1:0];
    send_line(req);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Corners, full diagonals, vertical and horizontal walks, tiny and border cases
  task automatic test_directed();
    send_points(0, 0, 0, 0);
    send_points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_points(0, 0, COORD_MAX, COORD_MAX);
    send_points(COORD_MAX, COORD_MAX, 0, 0);
    send_points(0, COORD_MAX, COORD_MAX, 0);
    send_points(COORD_MAX, 0, 0, COORD_MAX);
    send_points('h0580, 'h0100, 'h0580, 'h1E80);
    send_points('h0580, 'h1E80, 'h0580, 'h0100);
    send_points('h0510, 'h0300, 'h05F0, 'h1200);
    send_points('h1FFF, 'h0000, 'h1F00, 'h1FFF);
    send_points('h0020, 'h0A40, 'h1F00, 'h0AC0);
    send_points('h1FFF, 'h0A00, 'h0000, 'h0AFF);
    send_points('h0300, 'h0000, 'h0480, 'h1FFF);
    send_points('h0000, 'h0380, 'h1FFF, 'h0500);
    send_points('h1A80, 'h0240, 'h0340, 'h1C10);
    send_points('h0410, 'h0420, 'h04F0, 'h04E0);
    send_points('h0200, 'h0200, 'h0600, 'h0900);
    send_points('h0700, 'h1500, 'h0200, 'h0300);
  endtask

  // Mix of fully random, short, same-column, same-row and exactly vertical lines
  task automatic test_random_lines();
    int sx, sy, ex, ey, pick, off;
    for (int n = 0; n < RANDOM_LINES; n++) begin
      sx   = $urandom_range(0, COORD_MAX);
      sy   = $urandom_range(0, COORD_MAX);
      ex   = $urandom_range(0, COORD_MAX);
      ey   = $urandom_range(0, COORD_MAX);
      pick = $urandom_range(0, 9);
      if (pick >= 4 && pick < 7) begin
        off = $urandom_range(0, 1536);
        ex  = clamp_coord(sx + off - 768);
        off = $urandom_range(0, 1536);
        ey  = clamp_coord(sy + off - 768);
      end else if (pick == 7) begin
        ex = (sx & ~255) | (ex & 255);
      end else if (pick == 8) begin
        ey = (sy & ~255) | (ey & 255);
      end else if (pick == 9) begin
        ex = sx;
      end
      send_points(sx, sy, ex, ey);
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_requests++;
    burst_left = 8;
    repeat (8)
      send_points($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  initial begin
    int wait_cycles;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lines();
    test_backpressure();
    in_valid <= 1'b0;
    for (wait_cycles = 0; tile_queue.size() != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++)
      @(posedge clk_i);
    if (tile_queue.size() != 0) begin
      $display("Timed out with %0d tiles still expected", tile_queue.size());
      $display("CHECKS FAILED");
    end else begin
      repeat (SETTLE_TIME) @(posedge clk_i);
      $display("Walked %0d line requests (corners, vertical, horizontal, short, random)",
               lines_sent);
      $display("and checked %0d tiles under input gaps, output stalls and a long hold-off",
               tiles_checked);
      $display("%0d errors", error_count);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Watchdog expired at %0t", $realtime);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
